>>> design/stk8_pkg.sv
`default_nettype none

package stk8_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int THR_W      = 18;

  localparam logic [3:0] DIR_LEFT  = 4'b0001;
  localparam logic [3:0] DIR_RIGHT = 4'b0010;
  localparam logic [3:0] DIR_UP    = 4'b0100;
  localparam logic [3:0] DIR_DOWN  = 4'b1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_INTERVAL = 3'd0,
    REG_MINIMUM_INTERVAL = 3'd1,
    REG_INTERVAL_STEP    = 3'd2,
    REG_REPEATS_BEFORE   = 3'd3,
    REG_PRESS_LEVEL      = 3'd4,
    REG_RELEASE_LEVEL    = 3'd5,
    REG_BIAS_SIZE        = 3'd6,
    REG_DIAGONAL_WIDTH   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  initial_interval;
    logic [7:0]  minimum_interval;
    logic [7:0]  interval_step;
    logic [7:0]  repeats_before_speedup;
    logic [7:0]  press_level;
    logic [7:0]  release_level;
    logic [12:0] bias_size;
    logic [13:0] diagonal_width;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    initial_interval:       8'd20,
    minimum_interval:       8'd4,
    interval_step:          8'd2,
    repeats_before_speedup: 8'd2,
    press_level:            8'd128,
    release_level:          8'd64,
    bias_size:              13'd0,
    diagonal_width:         14'd8192
  };

  typedef struct packed {
    logic [7:0] cnt;
    logic [7:0] intv;
    logic [7:0] rep;
  } axis_t;

  localparam logic [13:0] SECT_NOMINAL = 14'h2000;
  localparam logic [12:0] BIAS_SPLIT   = 13'h1000;

  typedef logic signed [THR_W-1:0] thr_t;

  localparam thr_t SECT_OFFS [8] = '{
    -18'sh7000, -18'sh5000, -18'sh3000, -18'sh1000,
     18'sh1000,  18'sh3000,  18'sh5000,  18'sh7000
  };

  localparam logic [3:0] SECT_DIRS [8] = '{
    DIR_UP, DIR_UP | DIR_LEFT, DIR_LEFT, DIR_LEFT | DIR_DOWN,
    DIR_DOWN, DIR_DOWN | DIR_RIGHT, DIR_RIGHT, DIR_RIGHT | DIR_UP
  };

endpackage

`default_nettype wire

>>> design/stk8_sector.sv
`default_nettype none

module stk8_sector (
  input  wire logic signed [15:0] angle,
  input  wire logic signed [13:0] bias,
  input  wire logic        [13:0] diagonal_width,
  output logic             [3:0]  sector
);
  import stk8_pkg::*;

  logic signed [14:0] diff;
  logic signed [14:0] half;
  thr_t ang_x;
  thr_t bias_x;
  thr_t half_x;
  thr_t thr [8];

  always_comb begin
    diff   = $signed({1'b0, SECT_NOMINAL}) - $signed({1'b0, diagonal_width});
    half   = diff >>> 1;
    ang_x  = THR_W'(angle);
    bias_x = THR_W'(bias);
    half_x = THR_W'(half);
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) begin
        thr[k] = bias_x + SECT_OFFS[k] + half_x;
      end else begin
        thr[k] = bias_x + SECT_OFFS[k] - half_x;
      end
    end
    // lowest-numbered matching edge wins; DIR_UP if none matches
    sector = DIR_UP;
    for (int k = 7; k >= 0; k--) begin
      if (ang_x < thr[k]) begin
        sector = SECT_DIRS[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/stk8_axis.sv
`default_nettype none

module stk8_axis (
  input  wire logic [1:0]    held,
  input  wire logic [1:0]    prev,
  input  wire logic [1:0]    query,
  input  wire logic          init,
  input  wire stk8_pkg::cfg_t  cfg,
  input  wire stk8_pkg::axis_t cur,
  output stk8_pkg::axis_t      nxt,
  output logic [1:0]         fire
);
  import stk8_pkg::*;

  function automatic axis_t fire_reload(axis_t s, cfg_t c);
    axis_t      r;
    logic [8:0] diff;
    r    = s;
    diff = {1'b0, s.intv} - {1'b0, c.interval_step};
    r.cnt = s.intv;
    if (s.rep == 8'd0) begin
      if (diff[8] || (diff[7:0] < c.minimum_interval)) begin
        r.intv = c.minimum_interval;
      end else begin
        r.intv = diff[7:0];
      end
    end else begin
      r.rep = s.rep - 8'd1;
    end
    return r;
  endfunction

  axis_t s0;
  axis_t s1;
  axis_t s2;

  always_comb begin
    s0 = cur;
    if (init) begin
      s0.cnt  = 8'd0;
      s0.intv = cfg.initial_interval;
      s0.rep  = cfg.repeats_before_speedup;
    end
    s1 = s0;
    if (((prev & held) != 2'b00) && (s0.cnt != 8'd0)) begin
      s1.cnt = s0.cnt - 8'd1;
    end
    fire = 2'b00;
    s2   = s1;
    if (query[0] && held[0] && (s1.cnt == 8'd0)) begin
      fire[0] = 1'b1;
      s2      = fire_reload(s1, cfg);
    end
    nxt = s2;
    if (query[1] && held[1] && (s2.cnt == 8'd0)) begin
      fire[1] = 1'b1;
      nxt     = fire_reload(s2, cfg);
    end
  end

endmodule

`default_nettype wire

>>> design/stick_eight_way_autorepeat.sv
// path: an accepted input transaction goes through the input register, then the output register, to out_valid
// throughput: one transaction per cycle; in_stall rises only while the
//   input register is full and the output register is held by out_stall
// reset (synchronous, active high): clears both valid flags and the stick
//   state, and returns all configuration registers to their default values
`default_nettype none

module stick_eight_way_autorepeat (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [stk8_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stk8_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              restart,
  input  wire logic [7:0]                        stick_level,
  input  wire logic signed [15:0]                stick_angle,
  input  wire logic [3:0]                        query_mask,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [3:0]                             direction,
  output logic                                   fire_left,
  output logic                                   fire_right,
  output logic                                   fire_up,
  output logic                                   fire_down
);
  import stk8_pkg::*;

  cfg_t cfg;

  logic              s1_valid;
  logic              s1_restart;
  logic [7:0]        s1_level;
  logic signed [15:0] s1_angle;
  logic [3:0]        s1_query;

  logic [3:0]        held_dirs;
  logic signed [13:0] angle_bias;
  axis_t             x_axis;
  axis_t             y_axis;

  logic              out_free;
  logic              advance;
  logic              accept;

  logic [3:0]        sector;
  logic [3:0]        held_next;
  logic signed [13:0] angle_bias_next;
  logic              x_init;
  logic              y_init;
  axis_t             x_axis_next;
  axis_t             y_axis_next;
  logic [1:0]        x_fire;
  logic [1:0]        y_fire;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign accept    = in_valid && !in_stall;

  stk8_sector u_sector (
    .angle          (s1_angle),
    .bias           (angle_bias),
    .diagonal_width (cfg.diagonal_width),
    .sector         (sector)
  );

  always_comb begin
    held_next       = held_dirs;
    angle_bias_next = angle_bias;
    if (s1_level == 8'd0) begin
      held_next = 4'd0;
    end else begin
      if (s1_level >= cfg.press_level) begin
        held_next = sector;
      end else if (s1_level < cfg.release_level) begin
        held_next = 4'd0;
      end else begin
        held_next = held_dirs & ~sector;
      end
      if (held_next != held_dirs) begin
        if (held_next == 4'd0) begin
          angle_bias_next = 14'sd0;
        end else if (s1_angle[12:0] > BIAS_SPLIT) begin
          angle_bias_next = $signed({1'b0, cfg.bias_size});
        end else begin
          angle_bias_next = -$signed({1'b0, cfg.bias_size});
        end
      end
    end
    x_init = (held_next[1:0] == 2'b00);
    y_init = (held_next[3:2] == 2'b00);
  end

  stk8_axis u_axis_x (
    .held  (held_next[1:0]),
    .prev  (held_dirs[1:0]),
    .query (s1_query[1:0]),
    .init  (x_init),
    .cfg   (cfg),
    .cur   (x_axis),
    .nxt   (x_axis_next),
    .fire  (x_fire)
  );

  stk8_axis u_axis_y (
    .held  (held_next[3:2]),
    .prev  (held_dirs[3:2]),
    .query (s1_query[3:2]),
    .init  (y_init),
    .cfg   (cfg),
    .cur   (y_axis),
    .nxt   (y_axis_next),
    .fire  (y_fire)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_INITIAL_INTERVAL: cfg.initial_interval       <= cfg_data[7:0];
        REG_MINIMUM_INTERVAL: cfg.minimum_interval       <= cfg_data[7:0];
        REG_INTERVAL_STEP:    cfg.interval_step          <= cfg_data[7:0];
        REG_REPEATS_BEFORE:   cfg.repeats_before_speedup <= cfg_data[7:0];
        REG_PRESS_LEVEL:      cfg.press_level            <= cfg_data[7:0];
        REG_RELEASE_LEVEL:    cfg.release_level          <= cfg_data[7:0];
        REG_BIAS_SIZE:        cfg.bias_size              <= cfg_data[12:0];
        REG_DIAGONAL_WIDTH:   cfg.diagonal_width         <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_restart <= restart;
      s1_level   <= stick_level;
      s1_angle   <= stick_angle;
      s1_query   <= query_mask;
    end
  end

  // stick state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_dirs  <= 4'd0;
      angle_bias <= 14'sd0;
      x_axis     <= '{cnt: 8'd0, intv: CFG_RESET.initial_interval,
                      rep: CFG_RESET.repeats_before_speedup};
      y_axis     <= '{cnt: 8'd0, intv: CFG_RESET.initial_interval,
                      rep: CFG_RESET.repeats_before_speedup};
    end else if (advance) begin
      if (s1_restart) begin
        held_dirs  <= 4'd0;
        angle_bias <= 14'sd0;
        x_axis     <= '{cnt: 8'd0, intv: cfg.initial_interval,
                        rep: cfg.repeats_before_speedup};
        y_axis     <= '{cnt: 8'd0, intv: cfg.initial_interval,
                        rep: cfg.repeats_before_speedup};
      end else begin
        held_dirs  <= held_next;
        angle_bias <= angle_bias_next;
        x_axis     <= x_axis_next;
        y_axis     <= y_axis_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      if (s1_restart) begin
        direction  <= 4'd0;
        fire_left  <= 1'b0;
        fire_right <= 1'b0;
        fire_up    <= 1'b0;
        fire_down  <= 1'b0;
      end else begin
        direction  <= held_next;
        fire_left  <= x_fire[0];
        fire_right <= x_fire[1];
        fire_up    <= y_fire[0];
        fire_down  <= y_fire[1];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/stk8_checker.sv
`default_nettype none

module stk8_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] direction,
  input wire logic       fire_left,
  input wire logic       fire_right,
  input wire logic       fire_up,
  input wire logic       fire_down
);

  // a held result transaction stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // input back-pressure only comes from a blocked output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with a free output register");

  // a fire needs its direction held
  a_fire_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!fire_left || direction[0]) && (!fire_right || direction[1]) &&
                  (!fire_up || direction[2]) && (!fire_down || direction[3]))
    else $error("fire without held direction");

  // opposite directions never held together
  a_no_opposite: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(direction[0] && direction[1]) && !(direction[2] && direction[3]))
    else $error("opposite directions held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stick_eight_way_autorepeat stk8_checker u_stk8_checker (.*);

`default_nettype wire
